// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache: transaction
// payloads, the stored entry layout and the recency-tracker commands.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KeyWidth = 32;
  localparam int ValWidth = 32;
  localparam int CapWidth = 5;

  localparam logic       ActionGet = 1'b0;
  localparam logic       ActionSet = 1'b1;
  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                action;
    logic signed [31:0]  lookup_key;
    logic signed [31:0]  data_value;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic signed [31:0]  read_value;
  } out_item_t;

  typedef struct packed {
    logic [KeyWidth-1:0] key;
    logic [ValWidth-1:0] value;
  } entry_t;

  // commands to the recency tracker
  typedef enum logic [1:0] {
    AGE_NONE,
    AGE_TOUCH,
    AGE_EVICT,
    AGE_INSERT
  } age_op_t;

endpackage

// ===== rtl/lkvc_mem.sv =====
// ----------------------------------------------------------------------------
// lkvc_mem
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module lkvc_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  lkvc_pkg::entry_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output lkvc_pkg::entry_t rd_data
);

  lkvc_pkg::entry_t mem_r [DEPTH];
  lkvc_pkg::entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lkvc_age.sv =====
// ----------------------------------------------------------------------------
// lkvc_age
// Valid bits, per-entry recency ages and the occupancy count. Ages of valid
// entries always run 0..used-1, with 0 the most recent.
// ----------------------------------------------------------------------------
module lkvc_age #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int UW    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lkvc_pkg::age_op_t op,
  input  logic [AW-1:0]     idx,
  output logic [DEPTH-1:0]  valid,
  output logic [UW-1:0]     used,
  output logic [AW-1:0]     oldest_idx
);

  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [AW-1:0]    rec_r [DEPTH];
  logic [AW-1:0]    rec_nxt [DEPTH];
  logic [UW-1:0]    used_r, used_nxt;
  logic [DEPTH-1:0] oldest_hit;
  logic [AW-1:0]    oldest_sel;
  logic [AW-1:0]    oldest_age;
  logic [AW-1:0]    touch_age;

  // oldest valid entry carries age used-1
  assign oldest_age = AW'(used_r - UW'(1));
  always_comb begin
    oldest_sel = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      oldest_hit[i] = valid_r[i] && (rec_r[i] == oldest_age);
      if (oldest_hit[i]) oldest_sel = AW'(i);
    end
  end

  assign touch_age = rec_r[idx];

  // next-state for the age row
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    for (int i = 0; i < DEPTH; i++) rec_nxt[i] = rec_r[i];
    case (op)
      lkvc_pkg::AGE_TOUCH: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_r[i] && (rec_r[i] < touch_age)) rec_nxt[i] = rec_r[i] + AW'(1);
        end
        rec_nxt[idx] = '0;
      end
      lkvc_pkg::AGE_EVICT: begin
        valid_nxt[oldest_sel] = 1'b0;
        rec_nxt[oldest_sel]   = '0;
        used_nxt              = used_r - UW'(1);
      end
      lkvc_pkg::AGE_INSERT: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_r[i]) rec_nxt[i] = rec_r[i] + AW'(1);
        end
        valid_nxt[idx] = 1'b1;
        rec_nxt[idx]   = '0;
        used_nxt       = used_r + UW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      for (int i = 0; i < DEPTH; i++) rec_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      for (int i = 0; i < DEPTH; i++) rec_r[i] <= rec_nxt[i];
    end
  end

  assign valid      = valid_r;
  assign used       = used_r;
  assign oldest_idx = oldest_sel;

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// Transactions are handled one at a time: in_stall is high while a transaction is in progress.
// Every transaction scans all entries; the scan reads the entry memory one address per cycle.
// A get then offers its result from the output register; a stalled result holds a get in place.
// A set that misses evicts least recent entries until the new one fits, unless capacity is zero.
// Reset (rst_n low, synchronous): all entries invalid, occupancy zero, capacity 16.
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lkvc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lkvc_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int UW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = AW + 1;
  localparam int EW = (UW > lkvc_pkg::CapWidth) ? UW : lkvc_pkg::CapWidth;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [4:0]          cap_r;
  lkvc_pkg::in_item_t  item_r, item_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  logic [31:0]         hit_val_r, hit_val_nxt;
  logic                free_vld_r, free_vld_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  lkvc_pkg::out_item_t out_data_r, out_data_nxt;

  lkvc_pkg::age_op_t   age_op;
  logic [AW-1:0]       age_idx;
  logic [MAX_ENTRIES-1:0] valid;
  logic [UW-1:0]       used;
  logic [AW-1:0]       oldest_idx;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  lkvc_pkg::entry_t    mem_wdata;
  logic [AW-1:0]       mem_raddr;
  lkvc_pkg::entry_t    mem_rdata;

  logic [EW-1:0]       cap_ext, cap_eff, used_ext;
  logic                scan_done;
  logic                out_free;

  lkvc_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  lkvc_age #(.DEPTH(MAX_ENTRIES), .AW(AW), .UW(UW)) u_age (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (age_op),
    .idx        (age_idx),
    .valid      (valid),
    .used       (used),
    .oldest_idx (oldest_idx)
  );

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 5'd16;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // effective capacity clipped to the entry count
  assign cap_ext  = EW'(cap_r);
  assign cap_eff  = (cap_ext > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : cap_ext;
  assign used_ext = EW'(used);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_done = (iss_r == CW'(MAX_ENTRIES)) && !chk_vld_r;
  assign mem_raddr = iss_r[AW-1:0];

  // control and datapath next-state
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    iss_nxt       = iss_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_val_nxt   = hit_val_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    age_op        = lkvc_pkg::AGE_NONE;
    age_idx       = hit_idx_r;
    mem_we        = 1'b0;
    mem_waddr     = hit_idx_r;
    mem_wdata     = '{key: item_r.lookup_key, value: item_r.data_value};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_data;
          iss_nxt      = '0;
          hit_nxt      = 1'b0;
          free_vld_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, note the first free slot
        if (iss_r != CW'(MAX_ENTRIES)) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[AW-1:0];
          iss_nxt     = iss_r + CW'(1);
          if (!valid[iss_r[AW-1:0]] && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = iss_r[AW-1:0];
          end
        end
        // key compare on the returned entry
        if (chk_vld_r && valid[chk_idx_r] && (mem_rdata.key == item_r.lookup_key)) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = chk_idx_r;
          hit_val_nxt = mem_rdata.value;
        end
        if (scan_done) begin
          if (item_r.action == lkvc_pkg::ActionGet) begin
            if (hit_r) age_op = lkvc_pkg::AGE_TOUCH;
            state_nxt = ST_FINISH;
          end else if (hit_r) begin
            mem_we    = 1'b1;
            age_op    = lkvc_pkg::AGE_TOUCH;
            state_nxt = ST_IDLE;
          end else if (cap_eff == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EVICT;
          end
        end
      end

      ST_EVICT: begin
        if ((used_ext >= cap_eff) && (used != '0)) begin
          // drop the least recent entry, its slot may become the lowest free one
          age_op = lkvc_pkg::AGE_EVICT;
          if (!free_vld_r || (oldest_idx < free_idx_r)) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = oldest_idx;
          end
        end else begin
          if (free_vld_r) begin
            age_op    = lkvc_pkg::AGE_INSERT;
            age_idx   = free_idx_r;
            mem_we    = 1'b1;
            mem_waddr = free_idx_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.hit        = hit_r;
          out_data_nxt.read_value = hit_r ? hit_val_r : lkvc_pkg::MissValue;
          state_nxt               = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      iss_r       <= '0;
      hit_r       <= 1'b0;
      free_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      iss_r       <= iss_nxt;
      hit_r       <= hit_nxt;
      free_vld_r  <= free_vld_nxt;
    end
    item_r     <= item_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    free_idx_r <= free_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/lkvc_checker.sv =====
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lkvc_pkg::out_item_t out_data
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a miss always reads as all ones
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.read_value == lkvc_pkg::MissValue)
    else $error("miss result carries a value");

  // one transaction in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted during lookup");

  // reset leaves no result and an idle input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or busy state survives reset");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/tb_lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Self-checking bench for the LRU key-value cache. A behavioral LRU store
// predicts every get response, and a scoreboard class compares the responses
// in order. Several capacity settings are exercised, zero and the maximum
// among them. Keys come from a small pool, so hits and evictions happen often.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;

  localparam int Depth = 16;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  lkvc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  lkvc_pkg::out_item_t out_data;
  logic                cfg_wr_en;
  logic [4:0]          cfg_wr_data;

  int  mismatch_count;
  bit  quiet_phase;

  // behavioral copy of the store
  logic        lru_valid [Depth];
  logic [31:0] lru_key   [Depth];
  logic [31:0] lru_value [Depth];
  int          lru_age   [Depth];
  int          lru_used;
  logic [4:0]  lru_capacity;

  lru_key_value_cache_top #(.MAX_ENTRIES(Depth)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // scoreboard of pending get responses
  class response_board;
    lkvc_pkg::out_item_t pending_responses[$];

    function void note_request(lkvc_pkg::out_item_t predicted);
      pending_responses.push_back(predicted);
    endfunction

    task check_response(lkvc_pkg::out_item_t got);
      lkvc_pkg::out_item_t want;
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response hit=%0d value=%h",
                                  got.hit, got.read_value));
      end else begin
        want = pending_responses.pop_front();
        if (got.hit !== want.hit)
          report_mismatch($sformatf("hit got %0d want %0d", got.hit, want.hit));
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %h want %h",
                                    got.read_value, want.read_value));
      end
    endtask
  endclass

  response_board board;

  function automatic int lru_find(logic [31:0] key);
    for (int i = 0; i < Depth; i++)
      if (lru_valid[i] && lru_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void lru_touch(int idx);
    int old_age;
    old_age = lru_age[idx];
    for (int i = 0; i < Depth; i++)
      if (lru_valid[i] && lru_age[i] < old_age) lru_age[i]++;
    lru_age[idx] = 0;
  endfunction

  function automatic void lru_insert(logic [31:0] key, logic [31:0] value);
    int cap;
    int oldest;
    int slot;
    cap = (lru_capacity > Depth) ? Depth : int'(lru_capacity);
    if (cap == 0) return;
    // evict until the new entry fits
    while (lru_used >= cap && lru_used > 0) begin
      oldest = -1;
      for (int i = 0; i < Depth; i++)
        if (lru_valid[i] && (oldest < 0 || lru_age[i] > lru_age[oldest])) oldest = i;
      if (oldest >= 0) begin
        lru_valid[oldest] = 1'b0;
        lru_age[oldest] = 0;
        lru_used--;
      end
    end
    slot = -1;
    for (int i = Depth - 1; i >= 0; i--)
      if (!lru_valid[i]) slot = i;
    if (slot < 0) return;
    for (int i = 0; i < Depth; i++)
      if (lru_valid[i]) lru_age[i]++;
    lru_valid[slot] = 1'b1;
    lru_key[slot] = key;
    lru_value[slot] = value;
    lru_age[slot] = 0;
    lru_used++;
  endfunction

  // update the store for one request; returns 1 with a response for a get
  function automatic bit lru_access(lkvc_pkg::in_item_t req,
                                    output lkvc_pkg::out_item_t resp);
    int idx;
    idx = lru_find(req.lookup_key);
    resp.hit = 1'b0;
    resp.read_value = lkvc_pkg::MissValue;
    if (req.action == lkvc_pkg::ActionGet) begin
      if (idx >= 0) begin
        lru_touch(idx);
        resp.hit = 1'b1;
        resp.read_value = lru_value[idx];
      end
      return 1'b1;
    end
    if (idx >= 0) begin
      lru_value[idx] = req.data_value;
      lru_touch(idx);
    end else begin
      lru_insert(req.lookup_key, req.data_value);
    end
    return 1'b0;
  endfunction

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // response side: random stall bursts, check every response that is taken
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_response(out_data);
      if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 7);
        out_stall <= 1'b1;
      end
    end
  end

  task automatic send_request(logic action, logic [31:0] key, logic [31:0] value);
    lkvc_pkg::in_item_t  req;
    lkvc_pkg::out_item_t resp;
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end else begin
      // the previous deassert takes its own edge; the block is still busy then
      @(posedge clk);
    end
    req.action = action;
    req.lookup_key = key;
    req.data_value = value;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (lru_access(req, resp)) board.note_request(resp);
    in_valid <= 1'b0;
  endtask

  // wait out all responses plus the scan latency, then write capacity
  task automatic drain_and_set_capacity(logic [4:0] cap);
    while (board.pending_responses.size() != 0) @(posedge clk);
    repeat (4 * (Depth + 3) + 40) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    lru_capacity = cap;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'($urandom_range(0, 23)) ^ 32'hA5A5_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // stimulus
  initial begin
    logic [4:0] caps [6];
    board = new();
    mismatch_count = 0;
    quiet_phase = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    lru_capacity = 5'd16;
    lru_used = 0;
    for (int i = 0; i < Depth; i++) begin
      lru_valid[i] = 1'b0;
      lru_age[i] = 0;
      lru_key[i] = '0;
      lru_value[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: miss on empty, extremes, hit, update, eviction at capacity two
    send_request(lkvc_pkg::ActionGet, 32'h0, 32'h0);
    send_request(lkvc_pkg::ActionSet, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkvc_pkg::ActionSet, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lkvc_pkg::ActionSet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::ActionGet, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::ActionGet, 32'hFFFF_FFFF, 32'h0);
    send_request(lkvc_pkg::ActionSet, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(lkvc_pkg::ActionGet, 32'h7FFF_FFFF, 32'h0);
    // shrink below occupancy: next missing set evicts down to fit
    drain_and_set_capacity(5'd2);
    send_request(lkvc_pkg::ActionGet, 32'h8000_0000, 32'h0);
    send_request(lkvc_pkg::ActionSet, 32'h0000_0001, 32'h0000_0011);
    send_request(lkvc_pkg::ActionGet, 32'hFFFF_FFFF, 32'h0);
    send_request(lkvc_pkg::ActionGet, 32'h7FFF_FFFF, 32'h0);
    send_request(lkvc_pkg::ActionGet, 32'h8000_0000, 32'h0);
    // capacity zero keeps nothing
    drain_and_set_capacity(5'd0);
    send_request(lkvc_pkg::ActionSet, 32'h0000_0055, 32'h0000_0066);
    send_request(lkvc_pkg::ActionGet, 32'h0000_0055, 32'h0);
    // capacity above the depth acts as the depth
    drain_and_set_capacity(5'd31);
    for (int i = 0; i < 18; i++)
      send_request(lkvc_pkg::ActionSet, 32'h100 + 32'(i), 32'(i));
    send_request(lkvc_pkg::ActionGet, 32'h100, 32'h0);
    send_request(lkvc_pkg::ActionGet, 32'h111, 32'h0);

    // random phases across several capacities
    caps[0] = 5'd16; caps[1] = 5'd1; caps[2] = 5'd5;
    caps[3] = 5'd0;  caps[4] = 5'd31; caps[5] = 5'd9;
    for (int p = 0; p < 6; p++) begin
      drain_and_set_capacity(caps[p]);
      if (p == 5) quiet_phase = 1'b1;
      for (int n = 0; n < 330; n++)
        send_request(logic'($urandom_range(0, 1)), pick_key(), pick_value());
    end

    while (board.pending_responses.size() != 0) @(posedge clk);
    repeat (4 * (Depth + 3)) @(posedge clk);
    if (mismatch_count == 0 && board.pending_responses.size() == 0) begin
      $display("lru_key_value_cache_top verification clean");
    end else begin
      $display("lru_key_value_cache_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("lru_key_value_cache_top verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_mem.sv
rtl/lkvc_age.sv
rtl/lru_key_value_cache_top.sv
rtl/lkvc_checker.sv
verif/tb_lru_key_value_cache_top.sv
